@@ rtl/bmp24_pkg.sv @@
// bmp24_pkg: types and constants of the 24-bit BMP stream decoder.
// No dependencies; used by bmp24_stream_decoder and its checker.
package bmp24_pkg;

	typedef enum logic [6:0] {
		PH_WAIT   = 7'b0000001,
		PH_HEADER = 7'b0000010,
		PH_SKIP   = 7'b0000100,
		PH_PIXEL  = 7'b0001000,
		PH_PAD    = 7'b0010000,
		PH_DONE   = 7'b0100000,
		PH_ERROR  = 7'b1000000
	} phase_t;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] ERR_MAGIC       = 3'd0;
	localparam logic [2:0] ERR_HEADER_SIZE = 3'd1;
	localparam logic [2:0] ERR_BPP         = 3'd2;
	localparam logic [2:0] ERR_COMPRESSED  = 3'd3;
	localparam logic [2:0] ERR_SIZE        = 3'd4;
	localparam logic [2:0] ERR_MAX         = 3'd4;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;

	localparam logic [31:0] HDR_INFO = 32'd40;
	localparam logic [31:0] HDR_CORE = 32'd12;
	localparam logic [15:0] BPP_24   = 16'd24;
	localparam logic [31:0] MIN_OFS_INFO = 32'd54;
	localparam logic [31:0] MIN_OFS_CORE = 32'd26;

	// byte offsets of the last byte of each header field; for the compression field, of its second byte
	localparam logic [31:0] POS_MAGIC_B   = 32'd0;
	localparam logic [31:0] POS_MAGIC_M   = 32'd1;
	localparam logic [31:0] POS_OFFSET    = 32'd13;
	localparam logic [31:0] POS_HDR_SIZE  = 32'd17;
	localparam logic [31:0] POS_INFO_W    = 32'd21;
	localparam logic [31:0] POS_INFO_H    = 32'd25;
	localparam logic [31:0] POS_INFO_BPP  = 32'd29;
	localparam logic [31:0] POS_INFO_COMP = 32'd31;
	localparam logic [31:0] POS_CORE_W    = 32'd19;
	localparam logic [31:0] POS_CORE_H    = 32'd21;
	localparam logic [31:0] POS_CORE_BPP  = 32'd25;

	localparam int OUT_TDATA_W = 80;

	typedef struct packed {
		logic [2:0]  error_code;
		logic [12:0] image_height;
		logic [12:0] image_width;
		logic [11:0] stored_row;
		logic [11:0] column;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} result_t;

endpackage

@@ rtl/bmp24_stream_decoder.sv @@
// bmp24_stream_decoder: byte-stream decoder for 24-bit BMP files.
// Depends on bmp24_pkg.
//
// channel | dir | tdata (low bit up)                                      | tuser        | tlast
// s       | in  | data_byte[7:0]                                          | start_of_file| -
// m       | out | red,green,blue,column,stored_row,image_width,           | kind[1:0]    | last_pixel
//         |     | image_height,error_code, zero fill to 80 bits           |              |
//
// One byte per cycle unless a result is held by a stalled m side; a byte passes an input
// register, then the parse logic writes parser state and the result register.
// arst_n clears the parser to waiting for a start-of-file byte; no clearing pass.
// A stalled m side holds the result; one more byte is taken into the input register,
// and bytes that cause no result keep flowing while the result waits.
module bmp24_stream_decoder #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // data_byte
	input  logic                                s_tuser,  // start_of_file
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bmp24_pkg::OUT_TDATA_W-1:0]   m_tdata,  // red, green, blue, column,
	                                                      // stored_row, image_width,
	                                                      // image_height, error_code
	output logic [1:0]                          m_tuser,  // kind
	output logic                                m_tlast   // last_pixel
);
	import bmp24_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int WH = $clog2(MAX_HEIGHT + 1);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        sof_s1;
	logic        adv;

	phase_t      ph_q, cur_ph, n_ph;
	logic [31:0] bpos_q, cur_bpos, n_bpos;
	logic [31:0] acc_q, cur_acc, n_acc;
	logic        core_q, cur_core, n_core;
	logic [WW-1:0] wid_q, cur_wid, n_wid;
	logic [WH-1:0] hgt_q, cur_hgt, n_hgt;
	logic [31:0] dstart_q, cur_dstart, n_dstart;
	logic [WW-1:0] col_q, cur_col, n_col;
	logic [WH-1:0] row_q, cur_row, n_row;
	logic [1:0]  bip_q, cur_bip, n_bip;
	logic [1:0]  pad_q, cur_pad, n_pad;
	logic [7:0]  hb_q, cur_hb, n_hb;
	logic [7:0]  hg_q, cur_hg, n_hg;
	logic        sfault_q, cur_sfault, n_sfault;

	logic        res_valid;
	logic [1:0]  res_kind;
	logic        res_last;
	result_t     res;
	logic        do_pixel;
	logic        last;
	logic [31:0] a;
	logic [31:0] col32, row32, wid32, hgt32;

	result_t     out_q;
	logic [1:0]  kind_q;
	logic        last_q;

	assign adv      = valid_s1 && (!res_valid || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_comb begin
		if (sof_s1) begin
			cur_ph     = PH_HEADER;
			cur_bpos   = '0;
			cur_acc    = '0;
			cur_core   = 1'b0;
			cur_wid    = '0;
			cur_hgt    = '0;
			cur_dstart = '0;
			cur_col    = '0;
			cur_row    = '0;
			cur_bip    = '0;
			cur_pad    = '0;
			cur_hb     = '0;
			cur_hg     = '0;
			cur_sfault = 1'b0;
		end else begin
			cur_ph     = ph_q;
			cur_bpos   = bpos_q;
			cur_acc    = acc_q;
			cur_core   = core_q;
			cur_wid    = wid_q;
			cur_hgt    = hgt_q;
			cur_dstart = dstart_q;
			cur_col    = col_q;
			cur_row    = row_q;
			cur_bip    = bip_q;
			cur_pad    = pad_q;
			cur_hb     = hb_q;
			cur_hg     = hg_q;
			cur_sfault = sfault_q;
		end

		n_ph     = cur_ph;
		n_bpos   = cur_bpos;
		n_acc    = cur_acc;
		n_core   = cur_core;
		n_wid    = cur_wid;
		n_hgt    = cur_hgt;
		n_dstart = cur_dstart;
		n_col    = cur_col;
		n_row    = cur_row;
		n_bip    = cur_bip;
		n_pad    = cur_pad;
		n_hb     = cur_hb;
		n_hg     = cur_hg;
		n_sfault = cur_sfault;

		res_valid = 1'b0;
		res_kind  = KIND_PIXEL;
		res_last  = 1'b0;
		res       = '0;
		do_pixel  = 1'b0;
		last      = 1'b0;

		a     = {byte_s1, cur_acc[31:8]};
		col32 = 32'(cur_col);
		row32 = 32'(cur_row);
		wid32 = 32'(cur_wid);
		hgt32 = 32'(cur_hgt);

		case (cur_ph)
			PH_HEADER: begin
				n_acc  = a;
				n_bpos = cur_bpos + 32'd1;
				if (cur_bpos == POS_MAGIC_B) begin
					if (byte_s1 != MAGIC_B) begin
						res_valid = 1'b1; res_kind = KIND_ERROR; res.error_code = ERR_MAGIC;
					end
				end else if (cur_bpos == POS_MAGIC_M) begin
					if (byte_s1 != MAGIC_M) begin
						res_valid = 1'b1; res_kind = KIND_ERROR; res.error_code = ERR_MAGIC;
					end
				end else if (cur_bpos == POS_OFFSET) begin
					n_dstart = a;
				end else if (cur_bpos == POS_HDR_SIZE) begin
					if (a == HDR_INFO) begin
						n_core = 1'b0;
					end else if (a == HDR_CORE) begin
						n_core = 1'b1;
					end else begin
						res_valid = 1'b1; res_kind = KIND_ERROR; res.error_code = ERR_HEADER_SIZE;
					end
				end else if (!cur_core) begin
					if (cur_bpos == POS_INFO_W) begin
						n_wid = a[WW-1:0];
						if (a == 32'd0 || a > 32'(MAX_WIDTH)) n_sfault = 1'b1;
					end else if (cur_bpos == POS_INFO_H) begin
						n_hgt = a[WH-1:0];
						if (a == 32'd0 || a > 32'(MAX_HEIGHT)) n_sfault = 1'b1;
					end else if (cur_bpos == POS_INFO_BPP) begin
						if (a[31:16] != BPP_24) begin
							res_valid = 1'b1; res_kind = KIND_ERROR; res.error_code = ERR_BPP;
						end
					end else if (cur_bpos == POS_INFO_COMP) begin
						res_valid = 1'b1;
						if (a[31:16] != 16'd0) begin
							res_kind = KIND_ERROR; res.error_code = ERR_COMPRESSED;
						end else if (cur_sfault || cur_dstart < MIN_OFS_INFO) begin
							res_kind = KIND_ERROR; res.error_code = ERR_SIZE;
						end else begin
							res_kind = KIND_HEADER;
						end
					end
				end else begin
					if (cur_bpos == POS_CORE_W) begin
						n_wid = a[16+WW-1:16];
						if (a[31:16] == 16'd0 || 32'(a[31:16]) > 32'(MAX_WIDTH)) n_sfault = 1'b1;
					end else if (cur_bpos == POS_CORE_H) begin
						n_hgt = a[16+WH-1:16];
						if (a[31:16] == 16'd0 || 32'(a[31:16]) > 32'(MAX_HEIGHT)) n_sfault = 1'b1;
					end else if (cur_bpos == POS_CORE_BPP) begin
						res_valid = 1'b1;
						if (a[31:16] != BPP_24) begin
							res_kind = KIND_ERROR; res.error_code = ERR_BPP;
						end else if (cur_sfault || cur_dstart < MIN_OFS_CORE) begin
							res_kind = KIND_ERROR; res.error_code = ERR_SIZE;
						end else begin
							res_kind = KIND_HEADER;
						end
					end
				end
				if (res_valid) begin
					if (res_kind == KIND_HEADER) begin
						n_ph = PH_SKIP;
						res.image_width  = wid32[12:0];
						res.image_height = hgt32[12:0];
					end else begin
						n_ph = PH_ERROR;
					end
				end
			end
			PH_SKIP: begin
				if (cur_bpos != cur_dstart) begin
					n_bpos = cur_bpos + 32'd1;
				end else begin
					n_ph     = PH_PIXEL;
					do_pixel = 1'b1;
				end
			end
			PH_PIXEL: begin
				do_pixel = 1'b1;
			end
			PH_PAD: begin
				n_pad = cur_pad - 2'd1;
				if (n_pad == 2'd0) begin
					n_col = '0;
					n_row = cur_row + WH'(1);
					n_ph  = PH_PIXEL;
				end
			end
			default: begin
			end
		endcase

		if (do_pixel) begin
			case (cur_bip)
				2'd0: begin
					n_hb  = byte_s1;
					n_bip = 2'd1;
				end
				2'd1: begin
					n_hg  = byte_s1;
					n_bip = 2'd2;
				end
				default: begin
					n_bip = 2'd0;
					last  = (cur_col + WW'(1) == cur_wid) && (cur_row + WH'(1) == cur_hgt);
					res_valid      = 1'b1;
					res_kind       = KIND_PIXEL;
					res_last       = last;
					res.red        = byte_s1;
					res.green      = cur_hg;
					res.blue       = cur_hb;
					res.column     = col32[11:0];
					res.stored_row = row32[11:0];
					if (last) begin
						n_ph = PH_DONE;
					end else if (cur_col + WW'(1) == cur_wid) begin
						n_pad = wid32[1:0];
						if (wid32[1:0] != 2'd0) begin
							n_col = cur_col + WW'(1);
							n_ph  = PH_PAD;
						end else begin
							n_col = '0;
							n_row = cur_row + WH'(1);
							n_ph  = PH_PIXEL;
						end
					end else begin
						n_col = cur_col + WW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_WAIT;
			bpos_q   <= '0;
			acc_q    <= '0;
			core_q   <= 1'b0;
			wid_q    <= '0;
			hgt_q    <= '0;
			dstart_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			bip_q    <= '0;
			pad_q    <= '0;
			hb_q     <= '0;
			hg_q     <= '0;
			sfault_q <= 1'b0;
		end else if (adv) begin
			ph_q     <= n_ph;
			bpos_q   <= n_bpos;
			acc_q    <= n_acc;
			core_q   <= n_core;
			wid_q    <= n_wid;
			hgt_q    <= n_hgt;
			dstart_q <= n_dstart;
			col_q    <= n_col;
			row_q    <= n_row;
			bip_q    <= n_bip;
			pad_q    <= n_pad;
			hb_q     <= n_hb;
			hg_q     <= n_hg;
			sfault_q <= n_sfault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv && res_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q  <= res;
			kind_q <= res_kind;
			last_q <= res_last;
		end
	end

	assign m_tdata = {3'b000, out_q};
	assign m_tuser = kind_q;
	assign m_tlast = last_q;

endmodule

@@ rtl/bmp24_checker.sv @@
// bmp24_checker: port-level assertions for bmp24_stream_decoder.
// Depends on bmp24_pkg; bound to bmp24_stream_decoder at the end of this file.
module bmp24_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [bmp24_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                        m_tuser,
	input logic                              m_tlast
);
	import bmp24_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_PIXEL)
		else $error("last_pixel on non-pixel result");

	a_nonpixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_PIXEL |-> m_tdata[47:0] == 48'd0)
		else $error("pixel fields set on non-pixel result");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[76:74] <= ERR_MAX
			&& m_tdata[73:48] == 26'd0)
		else $error("bad error result");

endmodule

bind bmp24_stream_decoder bmp24_checker u_bmp24_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
